// ----- rtl/core/wsd_pkg.sv -----
`default_nettype none

package wsd_pkg;

    localparam int TEMP_W   = 16;
    localparam int TIME_W   = 48;
    localparam int WINDOW_W = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_HEATING = 2'd1;
    localparam logic [1:0] MODE_DONE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STABLE_DELTA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_TARGET   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HEAT = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic                     stable_event;
        logic                     timeout_event;
        logic signed [TEMP_W-1:0] last_temperature;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/warmup_stability_detector_unit.sv -----
`default_nettype none

// Warmup stability detector. Each transaction (start, temperature sample or
// time tick) produces exactly one result transaction carrying the mode after
// the item, stable and timeout flags and the latest sample temperature. All
// decisions for an item are made combinationally from the current state and
// the accepted input: one 49-bit timestamp subtract and compare per window and
// two 17-bit temperature differences. A new item is accepted every cycle while
// in_stall is low; a two-entry output stage (result register plus skid register)
// holds results while the downstream side stalls, and in_stall rises only
// when both entries are full. Configuration writes take effect on the next
// cycle and must only be issued while the block is idle.

module warmup_stability_detector_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [wsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wsd_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [1:0]                        operation,
    input  wire logic signed [wsd_pkg::TEMP_W-1:0] temperature,
    input  wire logic [wsd_pkg::TIME_W-1:0]        timestamp_ms,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [1:0]                        mode,
    output      logic                              stable_event,
    output      logic                              timeout_event,
    output      logic signed [wsd_pkg::TEMP_W-1:0] last_temperature
);
    import wsd_pkg::*;

    logic [TEMP_W-1:0]   stable_delta_reg;
    logic [WINDOW_W-1:0] stable_window_reg;
    logic [TEMP_W-1:0]   near_target_reg;
    logic [WINDOW_W-1:0] timeout_reg;

    state_t                   state_reg, state_next;
    logic                     have_ref_reg, have_ref_next;
    logic [TIME_W-1:0]        ref_time_reg, ref_time_next;
    logic                     have_anchor_reg, have_anchor_next;
    logic signed [TEMP_W-1:0] anchor_temp_reg, anchor_temp_next;
    logic [TIME_W-1:0]        anchor_time_reg, anchor_time_next;
    logic signed [TEMP_W-1:0] target_reg, target_next;
    logic signed [TEMP_W-1:0] latest_reg, latest_next;

    result_t out_reg, skid_reg, result;
    logic    out_valid_reg, skid_valid_reg;

    logic in_acc;
    logic out_acc;

    logic [TIME_W:0]       anchor_diff;
    logic [TIME_W:0]       ref_diff;
    logic [TIME_W-1:0]     ref_eff;
    logic                  anchor_elapsed;
    logic                  timeout_hit;
    logic signed [TEMP_W:0] dev_diff;
    logic signed [TEMP_W:0] tgt_diff;
    logic [TEMP_W:0]       dev_abs;
    logic [TEMP_W:0]       tgt_abs;
    logic                  dev_big;
    logic                  near_ok;
    logic                  stable_hit;
    logic                  timeout_fire;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid & ~in_stall;
    assign out_acc  = out_valid_reg & ~out_stall;

    assign out_valid        = out_valid_reg;
    assign mode             = out_reg.mode;
    assign stable_event     = out_reg.stable_event;
    assign timeout_event    = out_reg.timeout_event;
    assign last_temperature = out_reg.last_temperature;

    always_comb
    begin
        anchor_diff    = {1'b0, timestamp_ms} - {1'b0, anchor_time_reg};
        anchor_elapsed = ~anchor_diff[TIME_W] &&
                         (anchor_diff[TIME_W-1:0] >=
                          {{(TIME_W-WINDOW_W){1'b0}}, stable_window_reg});
        ref_eff        = have_ref_reg ? ref_time_reg : timestamp_ms;
        ref_diff       = {1'b0, timestamp_ms} - {1'b0, ref_eff};
        timeout_hit    = ~ref_diff[TIME_W] &&
                         (ref_diff[TIME_W-1:0] >=
                          {{(TIME_W-WINDOW_W){1'b0}}, timeout_reg});
        dev_diff       = {temperature[TEMP_W-1], temperature}
                         - {anchor_temp_reg[TEMP_W-1], anchor_temp_reg};
        tgt_diff       = {target_reg[TEMP_W-1], target_reg}
                         - {temperature[TEMP_W-1], temperature};
        dev_abs        = dev_diff[TEMP_W] ? 17'(-dev_diff) : 17'(dev_diff);
        tgt_abs        = tgt_diff[TEMP_W] ? 17'(-tgt_diff) : 17'(tgt_diff);
        dev_big        = dev_abs > {1'b0, stable_delta_reg};
        near_ok        = tgt_abs <= {1'b0, near_target_reg};
    end

    always_comb
    begin
        state_next       = state_reg;
        have_ref_next    = have_ref_reg;
        ref_time_next    = ref_time_reg;
        have_anchor_next = have_anchor_reg;
        anchor_temp_next = anchor_temp_reg;
        anchor_time_next = anchor_time_reg;
        target_next      = target_reg;
        latest_next      = latest_reg;
        stable_hit       = 1'b0;
        timeout_fire     = 1'b0;
        unique case (operation)
            OP_START:
            begin
                target_next      = temperature;
                state_next       = ST_HEAT;
                have_ref_next    = 1'b0;
                ref_time_next    = '0;
                have_anchor_next = 1'b0;
                anchor_temp_next = '0;
                anchor_time_next = '0;
            end
            OP_SAMPLE:
            begin
                latest_next = temperature;
                if (state_reg == ST_HEAT)
                begin
                    have_ref_next = 1'b1;
                    ref_time_next = ref_eff;
                    if (!have_anchor_reg || dev_big)
                    begin
                        have_anchor_next = 1'b1;
                        anchor_temp_next = temperature;
                        anchor_time_next = timestamp_ms;
                    end
                    else if (anchor_elapsed && near_ok)
                    begin
                        stable_hit = 1'b1;
                        state_next = ST_DONE;
                    end
                    if (!stable_hit && timeout_hit)
                    begin
                        timeout_fire = 1'b1;
                        state_next   = ST_DONE;
                    end
                end
            end
            OP_TICK:
            begin
                if (state_reg == ST_HEAT)
                begin
                    have_ref_next = 1'b1;
                    ref_time_next = ref_eff;
                    if (timeout_hit)
                    begin
                        timeout_fire = 1'b1;
                        state_next   = ST_DONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (state_next)
            ST_HEAT: result.mode = MODE_HEATING;
            ST_DONE: result.mode = MODE_DONE;
            default: result.mode = MODE_IDLE;
        endcase
        result.stable_event     = stable_hit;
        result.timeout_event    = timeout_fire;
        result.last_temperature = latest_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_delta_reg  <= TEMP_W'(8);
            stable_window_reg <= WINDOW_W'(30000);
            near_target_reg   <= TEMP_W'(32);
            timeout_reg       <= WINDOW_W'(600000);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STABLE_DELTA:  stable_delta_reg  <= cfg_data[TEMP_W-1:0];
                REG_STABLE_WINDOW: stable_window_reg <= cfg_data[WINDOW_W-1:0];
                REG_NEAR_TARGET:   near_target_reg   <= cfg_data[TEMP_W-1:0];
                REG_TIMEOUT:       timeout_reg       <= cfg_data[WINDOW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            have_ref_reg    <= 1'b0;
            ref_time_reg    <= '0;
            have_anchor_reg <= 1'b0;
            anchor_temp_reg <= '0;
            anchor_time_reg <= '0;
            target_reg      <= '0;
            latest_reg      <= '0;
        end
        else if (in_acc)
        begin
            state_reg       <= state_next;
            have_ref_reg    <= have_ref_next;
            ref_time_reg    <= ref_time_next;
            have_anchor_reg <= have_anchor_next;
            anchor_temp_reg <= anchor_temp_next;
            anchor_time_reg <= anchor_time_next;
            target_reg      <= target_next;
            latest_reg      <= latest_next;
        end
    end

    // advance the output stage; park a result in the skid slot when held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_acc || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_acc || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_acc)
            begin
                out_reg <= result;
            end
        end
        else if (in_acc)
        begin
            skid_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/wsd_checker.sv -----
`default_nettype none

module wsd_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic [1:0]                        operation,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [1:0]                        mode,
    input wire logic                              stable_event,
    input wire logic                              timeout_event,
    input wire logic signed [wsd_pkg::TEMP_W-1:0] last_temperature
);
    import wsd_pkg::*;

    // a held result transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mode)
            && $stable(stable_event) && $stable(timeout_event)
            && $stable(last_temperature))
        else $error("held result changed");

    // stall input only while a result is already waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(stable_event && timeout_event))
        else $error("stable and timeout in one result");

    a_event_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (stable_event || timeout_event) |-> mode == MODE_DONE)
        else $error("event reported without done mode");

    a_start_heat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == OP_START && !out_valid
            |=> out_valid && mode == MODE_HEATING && !stable_event && !timeout_event)
        else $error("start did not enter heating");

endmodule

bind warmup_stability_detector_unit wsd_checker u_wsd_checker (.*);

`default_nettype wire

// ----- sim/warmup_stability_detector_unit_tb.sv -----
module warmup_stability_detector_unit_tb;

    import wsd_pkg::*;

    localparam logic [1:0]        OP_UNUSED      = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};
    localparam int                WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [1:0]               op;
        logic signed [TEMP_W-1:0] temp;
        logic [TIME_W-1:0]        stamp;
    } warmup_txn_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 operation = OP_START;
    logic signed [TEMP_W-1:0]   temperature = '0;
    logic [TIME_W-1:0]          timestamp_ms = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [1:0]                 mode;
    logic                       stable_event;
    logic                       timeout_event;
    logic signed [TEMP_W-1:0]   last_temperature;

    warmup_stability_detector_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .temperature      (temperature),
        .timestamp_ms     (timestamp_ms),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .mode             (mode),
        .stable_event     (stable_event),
        .timeout_event    (timeout_event),
        .last_temperature (last_temperature)
    );

    warmup_txn_t pending_txns[$];
    result_t     expected_results[$];
    warmup_txn_t staged_txn;
    result_t     oldest_result;
    logic        in_taken = 1'b0;
    logic        hold_sender = 1'b0;
    logic        quiet = 1'b0;
    int          failures = 0;
    int          idle_cycles = 0;

    // settings in force for stimulus shaping
    logic [15:0] delta_set = 16'd8;
    logic [31:0] window_set = 32'd30000;
    logic [15:0] near_set = 16'd32;
    logic [31:0] timeout_set = 32'd600000;

    // predictor copy of configuration and state
    logic [15:0]              delta_cfg = 16'd8;
    logic [31:0]              window_cfg = 32'd30000;
    logic [15:0]              near_cfg = 16'd32;
    logic [31:0]              timeout_cfg = 32'd600000;
    logic [1:0]               heat_mode = MODE_IDLE;
    logic                     ref_valid = 1'b0;
    logic [TIME_W-1:0]        ref_time = '0;
    logic                     anchor_valid = 1'b0;
    logic signed [TEMP_W-1:0] anchor_temp = '0;
    logic [TIME_W-1:0]        anchor_time = '0;
    logic signed [TEMP_W-1:0] target_temp = '0;
    logic signed [TEMP_W-1:0] latest_temp = '0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int temp_gap(input int a, input int b);
        int d;
        d = a - b;
        return (d < 0) ? -d : d;
    endfunction

    function automatic bit window_passed(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] since,
                                         input logic [31:0] span);
        longint d;
        d = $signed({16'd0, now}) - $signed({16'd0, since});
        return d >= $signed({32'd0, span});
    endfunction

    function automatic bit timeout_due(input logic [TIME_W-1:0] now);
        if (ref_valid && window_passed(now, ref_time, timeout_cfg)) begin
            heat_mode = MODE_DONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t advance_warmup(input logic [1:0] op,
                                               input logic signed [TEMP_W-1:0] temp,
                                               input logic [TIME_W-1:0] stamp);
        result_t r;
        bit      stable_hit;
        bit      timeout_hit;
        stable_hit = 1'b0;
        timeout_hit = 1'b0;
        case (op)
            OP_START: begin
                target_temp = temp;
                heat_mode = MODE_HEATING;
                ref_valid = 1'b0;
                ref_time = '0;
                anchor_valid = 1'b0;
                anchor_temp = '0;
                anchor_time = '0;
            end
            OP_SAMPLE: begin
                latest_temp = temp;
                if (heat_mode == MODE_HEATING) begin
                    if (!ref_valid) begin
                        ref_valid = 1'b1;
                        ref_time = stamp;
                    end
                    if (!anchor_valid) begin
                        anchor_temp = temp;
                        anchor_time = stamp;
                        anchor_valid = 1'b1;
                    end else if (temp_gap(int'(temp), int'(anchor_temp)) >
                                 int'(delta_cfg)) begin
                        anchor_temp = temp;
                        anchor_time = stamp;
                    end else if (window_passed(stamp, anchor_time, window_cfg) &&
                                 temp_gap(int'(target_temp), int'(temp)) <=
                                 int'(near_cfg)) begin
                        heat_mode = MODE_DONE;
                        stable_hit = 1'b1;
                    end
                    if (!stable_hit)
                        timeout_hit = timeout_due(stamp);
                end
            end
            OP_TICK: begin
                if (heat_mode == MODE_HEATING) begin
                    if (!ref_valid) begin
                        ref_valid = 1'b1;
                        ref_time = stamp;
                    end
                    timeout_hit = timeout_due(stamp);
                end
            end
            default: ;
        endcase
        r.mode = heat_mode;
        r.stable_event = stable_hit;
        r.timeout_event = timeout_hit;
        r.last_temperature = latest_temp;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [15:0] want,
                                        input logic signed [15:0] got);
        if (got !== want) begin
            $display("%0t: ERROR %s expected %0d actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    // driver
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (hold_sender || pending_txns.size() == 0 ||
                (!quiet && $urandom_range(99) < 18)) begin
                in_valid <= 1'b0;
            end else begin
                staged_txn = pending_txns.pop_front();
                in_valid <= 1'b1;
                operation <= staged_txn.op;
                temperature <= staged_txn.temp;
                timestamp_ms <= staged_txn.stamp;
            end
        end
        out_stall <= rst_n && !quiet && ($urandom_range(99) < 18);
    end

    // monitor
    always @(posedge clk) begin
        in_taken <= in_valid && !in_stall;
        if (rst_n) begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_STABLE_DELTA:  delta_cfg = cfg_data[15:0];
                    REG_STABLE_WINDOW: window_cfg = cfg_data;
                    REG_NEAR_TARGET:   near_cfg = cfg_data[15:0];
                    REG_TIMEOUT:       timeout_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_results.push_back(advance_warmup(operation, temperature,
                                                          timestamp_ms));
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: ERROR unexpected result mode=%0d last_temperature=%0d",
                             $time, mode, last_temperature);
                    failures++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    check_field("mode", 16'(oldest_result.mode), 16'(mode));
                    check_field("stable_event", 16'(oldest_result.stable_event),
                                16'(stable_event));
                    check_field("timeout_event", 16'(oldest_result.timeout_event),
                                16'(timeout_event));
                    check_field("last_temperature", oldest_result.last_temperature,
                                last_temperature);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("warmup_stability_detector_unit: mismatch");
        $finish;
    end

    task automatic push_txn(input logic [1:0] op, input logic signed [TEMP_W-1:0] temp,
                            input logic [TIME_W-1:0] stamp);
        warmup_txn_t t;
        t.op = op;
        t.temp = temp;
        t.stamp = stamp;
        pending_txns.push_back(t);
    endtask

    task automatic write_settings(input logic [15:0] delta, input logic [31:0] window,
                                  input logic [15:0] near, input logic [31:0] timeout);
        delta_set = delta;
        window_set = window;
        near_set = near;
        timeout_set = timeout;
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_STABLE_DELTA;
        cfg_data <= {16'd0, delta};
        @(negedge clk);
        cfg_index <= REG_STABLE_WINDOW;
        cfg_data <= window;
        @(negedge clk);
        cfg_index <= REG_NEAR_TARGET;
        cfg_data <= {16'd0, near};
        @(negedge clk);
        cfg_index <= REG_TIMEOUT;
        cfg_data <= timeout;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_for_results(input bit whole_queue);
        do
            @(posedge clk);
        while ((whole_queue && pending_txns.size() != 0) || in_valid ||
               expected_results.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // warmup runs: a start, then samples settling toward the target, with ticks and noise
    task automatic queue_warmup_runs(input int budget);
        int                target;
        int                offset;
        int                jitter_max;
        int                run_len;
        logic [15:0]       raw16;
        logic [TIME_W-1:0] stamp;
        longint            span;
        jitter_max = (delta_set / 2 > 300) ? 300 : int'(delta_set / 2);
        span = longint'(window_set / 3) + 1;
        while (budget > 0) begin
            raw16 = 16'($urandom());
            target = ($urandom_range(3) == 0) ? int'($signed(raw16))
                                              : int'($urandom_range(800)) - 400;
            case ($urandom_range(3))
                0:       stamp = {16'($urandom()), 32'($urandom())};
                1:       stamp = TIME_MAX - TIME_W'($urandom_range(1000000));
                default: stamp = TIME_W'($urandom_range(100000));
            endcase
            push_txn(OP_START, 16'(target), {16'($urandom()), 32'($urandom())});
            offset = int'($urandom_range(4 * near_set + 128)) - int'(2 * near_set + 64);
            run_len = $urandom_range(14, 4);
            budget = budget - run_len - 1;
            repeat (run_len) begin
                case ($urandom_range(9))
                    0:       stamp = stamp + TIME_W'($urandom_range(40));
                    1:       stamp = stamp - TIME_W'($urandom_range(5000));
                    2:       stamp = stamp + TIME_W'($urandom());
                    3:       stamp = stamp + TIME_W'(timeout_set / 2) +
                                     TIME_W'($urandom_range(3));
                    default: stamp = stamp + TIME_W'(span) + TIME_W'($urandom_range(100));
                endcase
                raw16 = 16'($urandom());
                case ($urandom_range(99)) inside
                    [0:2]:   push_txn(OP_UNUSED, raw16, {16'($urandom()), 32'($urandom())});
                    [3:5]:   push_txn(OP_SAMPLE, raw16, stamp);
                    [6:7]:   push_txn(OP_TICK, raw16, {16'($urandom()), 32'($urandom())});
                    [8:24]:  push_txn(OP_TICK, raw16, stamp);
                    default: begin
                        offset = offset / 2 + int'($urandom_range(2 * jitter_max)) - jitter_max;
                        if ($urandom_range(9) == 0)
                            offset = offset + (($urandom_range(1) == 0) ? 1 : -1) *
                                     (int'(delta_set) + 1 + int'($urandom_range(50)));
                        push_txn(OP_SAMPLE, 16'(target + offset), stamp);
                    end
                endcase
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_txn(OP_TICK, 16'sd0, TIME_MAX);
        push_txn(OP_SAMPLE, -16'sd32768, '0);
        push_txn(OP_UNUSED, 16'sd32767, TIME_MAX);
        push_txn(OP_START, 16'sd32767, '0);
        push_txn(OP_SAMPLE, 16'sd32767, 48'd1000);
        push_txn(OP_SAMPLE, 16'sd32760, 48'd500);
        push_txn(OP_SAMPLE, 16'sd32767, 48'd31000);
        push_txn(OP_SAMPLE, 16'sd100, 48'd40000);
        push_txn(OP_TICK, 16'sd0, 48'd2000000);
        push_txn(OP_START, -16'sd32768, TIME_MAX);
        push_txn(OP_TICK, 16'sd0, TIME_MAX);
        push_txn(OP_SAMPLE, -16'sd32768, '0);
        push_txn(OP_SAMPLE, -16'sd32760, 48'd5);
        push_txn(OP_SAMPLE, 16'sd0, 48'd10);
        push_txn(OP_START, 16'sd0, '0);
        push_txn(OP_TICK, 16'sd0, '0);
        push_txn(OP_SAMPLE, 16'sd40, 48'd100);
        push_txn(OP_TICK, 16'sd0, 48'd599999);
        push_txn(OP_TICK, 16'sd0, 48'd600000);
        push_txn(OP_START, 16'sd16, '0);
        push_txn(OP_SAMPLE, 16'sd0, '0);
        push_txn(OP_SAMPLE, 16'sd0, 48'd700000);
        push_txn(OP_START, 16'sd0, '0);
        push_txn(OP_SAMPLE, 16'sd100, '0);
        push_txn(OP_SAMPLE, 16'sd100, 48'd30000);
        wait_for_results(1'b1);

        write_settings(16'd0, 32'd0, 16'd0, 32'd0);
        queue_warmup_runs(100);
        wait_for_results(1'b1);

        write_settings(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_warmup_runs(100);
        wait_for_results(1'b1);

        write_settings(16'($urandom_range(64, 8)), $urandom_range(5000, 100),
                       16'($urandom_range(200, 16)), $urandom_range(50000, 2000));
        @(posedge clk);
        quiet = 1'b1;
        queue_warmup_runs(120);
        wait_for_results(1'b1);
        quiet = 1'b0;

        write_settings(16'($urandom_range(64, 1)), $urandom_range(5000, 1),
                       16'($urandom_range(200, 1)), $urandom_range(50000, 1));
        queue_warmup_runs(140);
        while (pending_txns.size() > 70)
            @(posedge clk);
        hold_sender = 1'b1;
        wait_for_results(1'b0);
        hold_sender = 1'b0;
        wait_for_results(1'b1);

        write_settings(16'($urandom()), $urandom(), 16'($urandom()), $urandom());
        queue_warmup_runs(140);
        wait_for_results(1'b1);

        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("warmup_stability_detector_unit: match");
        else
            $display("warmup_stability_detector_unit: mismatch");
        $finish;
    end

endmodule
